// File: hw/rtl/pvadd_pkg.sv
// ----------------------------------------------------------------------------
// pvadd_pkg: shared constants for the polar vector adder
// Fixed-point scales, CORDIC gain factors, the arctangent table and the
// quadrant codes.
// ----------------------------------------------------------------------------
package pvadd_pkg;

  // Direction field width (whole degrees)
  localparam int DIR_W = 9;

  // Angle units of 2^-20 degree
  localparam int ANG_FRAC = 20;
  localparam int ANG_180  = 180 << ANG_FRAC;
  localparam int ANG_360  = 360 << ANG_FRAC;

  // Inverse CORDIC gain: Q30 on entry to rotation, Q16 on exit from vectoring
  localparam longint INVK_Q30 = 64'd652032874;
  localparam int     INVK_Q16 = 39797;
  localparam int     INVK_W   = 30;
  localparam int     INVK_Q16_W = 16;

  localparam int MAX_ITER = 24;

  // Quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) in units of 2^-20 degree
  function automatic int atan_deg(input int idx);
    int v;
    case (idx)
      0:  v = 47185920;
      1:  v = 27855475;
      2:  v = 14718068;
      3:  v = 7471121;
      4:  v = 3750058;
      5:  v = 1876857;
      6:  v = 938658;
      7:  v = 469357;
      8:  v = 234682;
      9:  v = 117342;
      10: v = 58671;
      11: v = 29335;
      12: v = 14668;
      13: v = 7334;
      14: v = 3667;
      15: v = 1833;
      16: v = 917;
      17: v = 458;
      18: v = 229;
      19: v = 115;
      20: v = 57;
      21: v = 29;
      22: v = 14;
      23: v = 7;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/pvadd_if.sv
// ----------------------------------------------------------------------------
// pvadd_in_if / pvadd_out_if: valid/ready channels of the polar vector adder
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pvadd_in_if #(
  parameter int PW = 16
);
  logic          valid;
  logic          ready;
  logic [PW-1:0] first_power;
  logic [8:0]    first_direction;
  logic [PW-1:0] second_power;
  logic [8:0]    second_direction;

  modport source (output valid, first_power, first_direction, second_power,
                  second_direction, input ready);
  modport sink   (input valid, first_power, first_direction, second_power,
                  second_direction, output ready);
endinterface

interface pvadd_out_if #(
  parameter int PW = 16
);
  logic        valid;
  logic        ready;
  logic [8:0]  sum_direction;
  logic [PW:0] sum_power;

  modport source (output valid, sum_direction, sum_power, input ready);
  modport sink   (input valid, sum_direction, sum_power, output ready);
endinterface

// File: hw/rtl/pvadd_cell.sv
// ----------------------------------------------------------------------------
// pvadd_cell: one CORDIC micro-rotation stage
// Rotation mode steers on the sign of z, vectoring mode on the sign of y.
// Carries a sideband word along with the vector.
// ----------------------------------------------------------------------------
module pvadd_cell import pvadd_pkg::*; #(
  parameter int CW        = 38,
  parameter int AW        = 30,
  parameter int SW        = 8,
  parameter int SHIFT     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [AW-1:0] z_i,
  input  logic        [SW-1:0] side_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [AW-1:0] z_o,
  output logic        [SW-1:0] side_o
);

  localparam logic signed [AW-1:0] ATAN = AW'(atan_deg(SHIFT));

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q;
  logic signed [AW-1:0] z_d, z_q;
  logic        [SW-1:0] side_q;
  logic                 neg_dir;

  // micro-rotation, shifts floor toward minus infinity
  always_comb begin
    dx      = y_i >>> SHIFT;
    dy      = x_i >>> SHIFT;
    neg_dir = VECTORING ? y_i[CW-1] : ~z_i[AW-1];
    if (neg_dir) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// File: hw/rtl/polar_vector_adder.sv
// ----------------------------------------------------------------------------
// polar_vector_adder: sum of two polar vectors by CORDIC
// Rotation CORDIC per vector to rectangular form, add, vectoring CORDIC back.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  beat: two magnitudes (unsigned Q8.8) and two directions in degrees.
//   out_ch beat: direction of the sum (0..359, truncated) and its magnitude
//                (unsigned Q9.8, saturating). A zero sum reads as 0 / 0.
//   Every input beat yields exactly one output beat, in order.
// Throughput: one beat per cycle while out_ch is ready, set by the unrolled
//   chain of CORDIC cells. Pipeline, from input beat to output valid: input
//   stage, rotation cells, add, fold, vectoring cells, output stage.
// Each stage has its own valid bit and loads when it is empty or when the
//   stage after it moves, so bubbles collapse and input is taken while a
//   result waits. When out_ch is stalled the pipe fills up; in_ch.ready drops
//   only once every stage holds a beat.
// Reset (rst_ni low, asynchronous) empties all stages; data registers keep
//   whatever they held.
// ----------------------------------------------------------------------------
module polar_vector_adder import pvadd_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int POWER_WIDTH       = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pvadd_in_if.sink     in_ch,
  pvadd_out_if.source  out_ch
);

  localparam int N   = CORDIC_ITERATIONS;
  localparam int PW  = POWER_WIDTH;
  localparam int CW  = PW + 22;
  localparam int AW  = 30;
  localparam int TW  = 32;
  localparam int RSW = PW + 3;       // rotation sideband: p, quadrant, exact
  localparam int VSW = DIR_W + 2;    // vectoring sideband: base, axis, dir
  localparam int NS  = 2 * N + 4;
  localparam int ST_ADD  = N + 1;
  localparam int ST_FOLD = N + 2;
  localparam int ST_OUT  = NS - 1;

  // --------------------------------------------------------------------------
  // Stage valids and ready chain
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ch.ready = rdy[0];

  // --------------------------------------------------------------------------
  // Input stage: reduce direction, split into quadrant, prescale magnitude
  // --------------------------------------------------------------------------
  logic [PW-1:0]       pw_in [2];
  logic [DIR_W-1:0]    dir_in [2];
  logic signed [CW-1:0] rx [2][N+1];
  logic signed [CW-1:0] ry [2][N+1];
  logic signed [AW-1:0] rz [2][N+1];
  logic [RSW-1:0]       rs [2][N+1];

  assign pw_in[0]  = in_ch.first_power;
  assign pw_in[1]  = in_ch.second_power;
  assign dir_in[0] = in_ch.first_direction;
  assign dir_in[1] = in_ch.second_direction;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DIR_W-1:0]  d_red;
    logic [1:0]        quad;
    logic [DIR_W-1:0]  rem;
    logic [PW+INVK_W-1:0] prod;
    logic signed [CW-1:0] x0_q;
    logic signed [AW-1:0] z0_q;
    logic [RSW-1:0]       s0_q;

    always_comb begin
      d_red = (dir_in[l] >= DIR_W'(360)) ? dir_in[l] - DIR_W'(360) : dir_in[l];
      if (d_red >= DIR_W'(270)) begin
        quad = QUAD_3;
        rem  = d_red - DIR_W'(270);
      end else if (d_red >= DIR_W'(180)) begin
        quad = QUAD_2;
        rem  = d_red - DIR_W'(180);
      end else if (d_red >= DIR_W'(90)) begin
        quad = QUAD_1;
        rem  = d_red - DIR_W'(90);
      end else begin
        quad = QUAD_0;
        rem  = d_red;
      end
      prod = (PW+INVK_W)'(pw_in[l]) * (PW+INVK_W)'(INVK_Q30);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        x0_q <= CW'(prod >> 14);
        z0_q <= AW'(rem) <<< ANG_FRAC;
        s0_q <= {pw_in[l], quad, (rem == '0)};
      end
    end

    assign rx[l][0] = x0_q;
    assign ry[l][0] = '0;
    assign rz[l][0] = z0_q;
    assign rs[l][0] = s0_q;

    // rotation chain
    for (genvar i = 0; i < N; i++) begin : g_rot
      pvadd_cell #(
        .CW(CW), .AW(AW), .SW(RSW), .SHIFT(i), .VECTORING(1'b0)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (rdy[i+1]),
        .x_i    (rx[l][i]),
        .y_i    (ry[l][i]),
        .z_i    (rz[l][i]),
        .side_i (rs[l][i]),
        .x_o    (rx[l][i+1]),
        .y_o    (ry[l][i+1]),
        .z_o    (rz[l][i+1]),
        .side_o (rs[l][i+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Add stage: pick exact or CORDIC cos/sin, map quadrant, sum components
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] cx [2];
  logic signed [CW-1:0] cy [2];
  logic signed [CW-1:0] sx_q, sy_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [CW-1:0] c, s;
      logic [PW-1:0] p;
      logic [1:0]    q;
      logic          exact;
      {p, q, exact} = rs[l][N];
      c = exact ? (CW'(p) <<< 16) : rx[l][N];
      s = exact ? '0 : ry[l][N];
      case (q)
        QUAD_0: begin cx[l] = c;  cy[l] = s;  end
        QUAD_1: begin cx[l] = -s; cy[l] = c;  end
        QUAD_2: begin cx[l] = -c; cy[l] = -s; end
        default: begin cx[l] = s; cy[l] = -c; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_ADD]) begin
      sx_q <= cx[0] + cx[1];
      sy_q <= cy[0] + cy[1];
    end
  end

  // --------------------------------------------------------------------------
  // Fold stage: axis and zero cases, fold left half plane into the right
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] vx [N+1];
  logic signed [CW-1:0] vy [N+1];
  logic signed [AW-1:0] vz [N+1];
  logic [VSW-1:0]       vs [N+1];
  logic [DIR_W-1:0]     dir_axis;
  logic                 on_axis, flip;
  logic signed [CW-1:0] fx_q, fy_q;
  logic [VSW-1:0]       fs_q;

  always_comb begin
    on_axis = (sx_q == '0) || (sy_q == '0);
    flip    = sx_q[CW-1];
    if (sx_q == '0 && sy_q == '0)  dir_axis = DIR_W'(0);
    else if (sy_q == '0)           dir_axis = sx_q[CW-1] ? DIR_W'(180) : DIR_W'(0);
    else                           dir_axis = sy_q[CW-1] ? DIR_W'(270) : DIR_W'(90);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_FOLD]) begin
      fx_q <= flip ? -sx_q : sx_q;
      fy_q <= flip ? -sy_q : sy_q;
      fs_q <= {flip, on_axis, dir_axis};
    end
  end

  assign vx[0] = fx_q;
  assign vy[0] = fy_q;
  assign vz[0] = '0;
  assign vs[0] = fs_q;

  // vectoring chain
  for (genvar i = 0; i < N; i++) begin : g_vec
    pvadd_cell #(
      .CW(CW), .AW(AW), .SW(VSW), .SHIFT(i), .VECTORING(1'b1)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (rdy[ST_FOLD+1+i]),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .side_i (vs[i]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .side_o (vs[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: angle to degrees, undo gain, round and saturate magnitude
  // --------------------------------------------------------------------------
  localparam int MW = CW - 8 + INVK_Q16_W + 1;
  logic signed [TW-1:0] t;
  logic [DIR_W-1:0]     dir_fin;
  logic [CW-9:0]        xs;
  logic [MW-1:0]        mprod;
  logic [MW-25:0]       mag;
  logic [PW:0]          mag_sat;
  logic                 base180, axis_f;
  logic [DIR_W-1:0]     dir_ax_f;
  logic [DIR_W-1:0]     dir_q;
  logic [PW:0]          pow_q;

  always_comb begin
    {base180, axis_f, dir_ax_f} = vs[N];
    t = (base180 ? TW'(ANG_180) : TW'(0)) + TW'(vz[N]);
    if (t < 0) t = t + TW'(ANG_360);
    if (t >= TW'(ANG_360)) t = t - TW'(ANG_360);
    dir_fin = DIR_W'(t >>> ANG_FRAC);
    if (dir_fin >= DIR_W'(360)) dir_fin = '0;
    if (axis_f) dir_fin = dir_ax_f;

    xs      = vx[N][CW-1] ? '0 : vx[N][CW-1:8];
    mprod   = MW'(xs) * MW'(INVK_Q16) + (MW'(1) << 23);
    mag     = mprod[MW-1:24];
    mag_sat = (mag > (MW-24)'({(PW+1){1'b1}})) ? {(PW+1){1'b1}} : mag[PW:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      dir_q <= dir_fin;
      pow_q <= mag_sat;
    end
  end

  assign out_ch.valid         = v_q[ST_OUT];
  assign out_ch.sum_direction = dir_q;
  assign out_ch.sum_power     = pow_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (&v_q))
    else $error("input stalled while pipeline has a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> v_q[0])
    else $error("accepted beat lost at input stage");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.sum_direction < DIR_W'(360)))
    else $error("sum_direction out of range");

endmodule

// File: sim/polar_vector_adder_test.sv
// ----------------------------------------------------------------------------
// polar_vector_adder_test: self-checking bench for the polar vector adder
// Drives pairs of polar vectors through the input channel, predicts the sum
// with a bit-exact CORDIC model and compares every output beat in order.
// The random test sends in bursts with gaps; the receiver stalls on its own
// pattern. One phase fills the pipe against a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polar_vector_adder_test import pvadd_pkg::*; ();

  localparam int ITERS      = 16;
  localparam int PW         = 16;
  localparam int LATENCY    = 2 * ITERS + 4;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [8:0]  dir;
    logic [PW:0] pwr;
  } sum_t;

  logic clk_i;
  logic rst_ni;

  pvadd_in_if  #(.PW(PW)) in_ch ();
  pvadd_out_if #(.PW(PW)) out_ch ();

  polar_vector_adder #(
    .CORDIC_ITERATIONS(ITERS),
    .POWER_WIDTH      (PW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sum_t   sums_pending[$];
  int     mismatches;
  int     idle_cycles;
  bit     timed_out;
  bit     hold_off;
  bit     burst_mode;
  int     burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Arithmetic shift right, rounding toward minus infinity
  function automatic longint shr(input longint v, input int n);
    return v >>> n;
  endfunction

  // Rectangular components of one polar vector, 24 fraction bits
  task automatic polar_to_rect(input logic [PW-1:0] pw, input logic [8:0] dir_in,
                               output longint cx, output longint cy);
    longint x, y, z, c, s, dx, dy;
    int     d, r;
    logic [1:0] q;
    d = dir_in;
    if (d >= 360) d -= 360;
    q = 2'(d / 90);
    r = d % 90;
    if (r == 0) begin
      c = longint'(pw) << 16;
      s = 0;
    end else begin
      x = longint'((64'(pw) * INVK_Q30) >> 14);
      y = 0;
      z = longint'(r) << ANG_FRAC;
      for (int i = 0; i < ITERS; i++) begin
        dx = shr(y, i);
        dy = shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_deg(i);
        end else begin
          x += dx; y -= dy; z += atan_deg(i);
        end
      end
      c = x;
      s = y;
    end
    case (q)
      QUAD_0: begin cx = c;  cy = s;  end
      QUAD_1: begin cx = -s; cy = c;  end
      QUAD_2: begin cx = -c; cy = -s; end
      default: begin cx = s; cy = -c; end
    endcase
  endtask

  // Expected sum of two polar vectors
  task automatic predict_sum(input logic [PW-1:0] p1, input logic [8:0] d1,
                             input logic [PW-1:0] p2, input logic [8:0] d2,
                             output sum_t res);
    longint ax, ay, bx, by, x, y, z, base, t, dx, dy, sx, sy;
    longint unsigned mag;
    int dirv;
    polar_to_rect(p1, d1, ax, ay);
    polar_to_rect(p2, d2, bx, by);
    sx = ax + bx;
    sy = ay + by;
    x = sx;
    y = sy;
    dirv = 0;
    if (x == 0 && y == 0) begin
      res = '0;
      return;
    end
    if (y == 0) dirv = (x > 0) ? 0 : 180;
    else if (x == 0) dirv = (y > 0) ? 90 : 270;
    base = 0;
    if (x < 0) begin
      x = -x; y = -y; base = ANG_180;
    end
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_deg(i);
      end else begin
        x -= dx; y += dy; z -= atan_deg(i);
      end
    end
    if (sx != 0 && sy != 0) begin
      t = base + z;
      if (t < 0) t += ANG_360;
      if (t >= ANG_360) t -= ANG_360;
      dirv = int'(t >>> ANG_FRAC);
      if (dirv >= 360) dirv = 0;
    end
    if (x < 0) x = 0;
    mag = (longint'(unsigned'(x >>> 8)) * INVK_Q16 + (64'd1 << 23)) >> 24;
    if (mag > (64'd1 << (PW + 1)) - 1) mag = (64'd1 << (PW + 1)) - 1;
    res.dir = dirv[8:0];
    res.pwr = mag[PW:0];
  endtask

  // Send one beat; the sender drops valid only during its gaps
  task automatic send_pair(input logic [PW-1:0] p1, input logic [8:0] d1,
                           input logic [PW-1:0] p2, input logic [8:0] d2);
    sum_t exp_sum;
    if (burst_mode) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    predict_sum(p1, d1, p2, d2, exp_sum);
    in_ch.valid            <= 1'b1;
    in_ch.first_power      <= p1;
    in_ch.first_direction  <= d1;
    in_ch.second_power     <= p2;
    in_ch.second_direction <= d2;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sums_pending.push_back(exp_sum);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (sums_pending.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  function automatic logic [8:0] any_dir();
    return 9'($urandom_range(0, 511));
  endfunction

  // Receiver: random stall pattern, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    sum_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sums_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: dir=%0d pwr=%0d",
                   out_ch.sum_direction, out_ch.sum_power);
      end else begin
        want = sums_pending.pop_front();
        if (out_ch.sum_direction !== want.dir || out_ch.sum_power !== want.pwr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: dir exp %0d got %0d, pwr exp %0d got %0d",
                     want.dir, out_ch.sum_direction, want.pwr, out_ch.sum_power);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("polar_vector_adder_test: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_pair(16'h0000, 9'd0,   16'h0000, 9'd0);
    send_pair(16'hFFFF, 9'd0,   16'hFFFF, 9'd0);
    send_pair(16'hFFFF, 9'd45,  16'hFFFF, 9'd45);
    send_pair(16'h0100, 9'd90,  16'h0100, 9'd270);
    send_pair(16'h0100, 9'd0,   16'h0100, 9'd180);
    send_pair(16'h0200, 9'd90,  16'h0000, 9'd0);
    send_pair(16'h0200, 9'd180, 16'h0000, 9'd7);
    send_pair(16'h0200, 9'd270, 16'h0000, 9'd359);
    send_pair(16'h0100, 9'd359, 16'h0000, 9'd0);
    send_pair(16'h0100, 9'd360, 16'h0100, 9'd511);
    send_pair(16'h0300, 9'd450, 16'h0001, 9'd1);
    send_pair(16'h0001, 9'd1,   16'h0001, 9'd359);
    send_pair(16'h1234, 9'd30,  16'h1234, 9'd210);
    send_pair(16'h8000, 9'd135, 16'h7FFF, 9'd225);
    send_pair(16'hFFFF, 9'd89,  16'hFFFF, 9'd91);
    send_pair(16'h0100, 9'd179, 16'h0100, 9'd181);
    send_pair(16'h5555, 9'd315, 16'hAAAA, 9'd300);
    send_pair(16'h0001, 9'd0,   16'h0000, 9'd0);
    drain();
  endtask

  task automatic test_random();
    burst_mode = 1'b1;
    for (int n = 0; n < 1800; n++) begin
      if ($urandom_range(0, 9) < 2)
        send_pair(16'($urandom), any_dir(), 16'($urandom), any_dir());
      else if ($urandom_range(0, 9) < 5)
        send_pair(16'($urandom_range(0, 1023)), 9'($urandom_range(0, 359)),
                  16'($urandom_range(0, 1023)), 9'($urandom_range(0, 359)));
      else
        send_pair(16'($urandom), 9'($urandom_range(0, 3) * 90),
                  16'($urandom), 9'($urandom_range(0, 359)));
    end
    burst_mode = 1'b0;
    drain();
  endtask

  // Fill the pipe against a stalled receiver, then let it drain
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 2 * LATENCY; n++)
        send_pair(16'($urandom), any_dir(), 16'($urandom), any_dir());
    join
    drain();
  endtask

  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    timed_out   = 1'b0;
    hold_off    = 1'b0;
    burst_mode  = 1'b0;
    burst_left  = 0;
    rst_ni      = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.first_power      = '0;
    in_ch.first_direction  = '0;
    in_ch.second_power     = '0;
    in_ch.second_direction = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random();

    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && sums_pending.size() == 0)
      $display("polar_vector_adder_test: PASS");
    else
      $display("polar_vector_adder_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pvadd_pkg.sv
hw/rtl/pvadd_if.sv
hw/rtl/pvadd_cell.sv
hw/rtl/polar_vector_adder.sv
sim/polar_vector_adder_test.sv
